### rtl/core/shamh_pkg.sv
// Shared types and constants for the SHA-256 message hasher.
// No dependencies; imported by every module of the block.
package shamh_pkg;

  localparam int unsigned WordW  = 32;
  localparam int unsigned Rounds = 64;

  localparam logic [7:0] PAD_MARK = 8'h80;

  localparam logic [WordW-1:0] INIT_HASH [8] = '{
    32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
    32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19
  };

  localparam logic [WordW-1:0] ROUND_K [Rounds] = '{
    32'h428A2F98, 32'h71374491, 32'hB5C0FBCF, 32'hE9B5DBA5,
    32'h3956C25B, 32'h59F111F1, 32'h923F82A4, 32'hAB1C5ED5,
    32'hD807AA98, 32'h12835B01, 32'h243185BE, 32'h550C7DC3,
    32'h72BE5D74, 32'h80DEB1FE, 32'h9BDC06A7, 32'hC19BF174,
    32'hE49B69C1, 32'hEFBE4786, 32'h0FC19DC6, 32'h240CA1CC,
    32'h2DE92C6F, 32'h4A7484AA, 32'h5CB0A9DC, 32'h76F988DA,
    32'h983E5152, 32'hA831C66D, 32'hB00327C8, 32'hBF597FC7,
    32'hC6E00BF3, 32'hD5A79147, 32'h06CA6351, 32'h14292967,
    32'h27B70A85, 32'h2E1B2138, 32'h4D2C6DFC, 32'h53380D13,
    32'h650A7354, 32'h766A0ABB, 32'h81C2C92E, 32'h92722C85,
    32'hA2BFE8A1, 32'hA81A664B, 32'hC24B8B70, 32'hC76C51A3,
    32'hD192E819, 32'hD6990624, 32'hF40E3585, 32'h106AA070,
    32'h19A4C116, 32'h1E376C08, 32'h2748774C, 32'h34B0BCB5,
    32'h391C0CB3, 32'h4ED8AA4A, 32'h5B9CCA4F, 32'h682E6FF3,
    32'h748F82EE, 32'h78A5636F, 32'h84C87814, 32'h8CC70208,
    32'h90BEFFFA, 32'hA4506CEB, 32'hBEF9A3F7, 32'hC67178F2
  };

  // source of the byte shifted into the block
  typedef enum logic [1:0] {
    SEL_DATA = 2'd0,
    SEL_MARK = 2'd1,
    SEL_ZERO = 2'd2,
    SEL_LEN  = 2'd3
  } byte_sel_t;

  typedef struct packed {
    logic      shift_byte;
    byte_sel_t byte_sel;
    logic      count_en;
    logic      init_vars;
    logic      round_en;
    logic [5:0] round;
    logic      fold;
    logic      clear_msg;
    logic      digest_load;
  } cmd_t;

  typedef struct packed {
    logic [5:0] pos;
  } stat_t;

endpackage

### rtl/core/shamh_ctrl.sv
// Sequencer for the hasher: byte loading, padding, compression rounds, digest hand-off.
// Depends on shamh_pkg; drives the datapath and digest buffer by command struct.
module shamh_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic            byte_valid,
  input  logic            last_byte,
  input  shamh_pkg::stat_t stat,
  input  logic            out_busy,
  output shamh_pkg::cmd_t cmd
);
  import shamh_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_PAD  = 5'b00010,
    S_COMP = 5'b00100,
    S_FOLD = 5'b01000,
    S_DONE = 5'b10000
  } state_t;

  state_t     state, state_next;
  logic [5:0] rnd, rnd_next;
  logic       pad_active, pad_active_next;
  logic       mark_done, mark_done_next;
  logic       len_phase, len_phase_next;
  logic       len_done, len_done_next;
  logic       block_full;

  assign block_full = (stat.pos == 6'd63);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      rnd        <= '0;
      pad_active <= 1'b0;
      mark_done  <= 1'b0;
      len_phase  <= 1'b0;
      len_done   <= 1'b0;
    end else begin
      state      <= state_next;
      rnd        <= rnd_next;
      pad_active <= pad_active_next;
      mark_done  <= mark_done_next;
      len_phase  <= len_phase_next;
      len_done   <= len_done_next;
    end
  end

  always_comb begin
    state_next      = state;
    rnd_next        = rnd;
    pad_active_next = pad_active;
    mark_done_next  = mark_done;
    len_phase_next  = len_phase;
    len_done_next   = len_done;
    in_ready        = 1'b0;
    cmd             = '0;
    cmd.byte_sel    = SEL_DATA;
    cmd.round       = rnd;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (byte_valid) begin
            cmd.shift_byte = 1'b1;
            cmd.count_en   = 1'b1;
          end
          if (byte_valid && block_full) begin
            cmd.init_vars   = 1'b1;
            pad_active_next = last_byte;
            state_next      = S_COMP;
          end else if (last_byte) begin
            pad_active_next = 1'b1;
            state_next      = S_PAD;
          end
        end
      end
      S_PAD: begin
        cmd.shift_byte = 1'b1;
        mark_done_next = 1'b1;
        if (!mark_done) begin
          cmd.byte_sel = SEL_MARK;
        end else if (len_phase || stat.pos == 6'd56) begin
          cmd.byte_sel   = SEL_LEN;
          len_phase_next = 1'b1;
        end else begin
          cmd.byte_sel = SEL_ZERO;
        end
        if (block_full) begin
          cmd.init_vars = 1'b1;
          len_done_next = (cmd.byte_sel == SEL_LEN);
          state_next    = S_COMP;
        end
      end
      S_COMP: begin
        cmd.round_en = 1'b1;
        rnd_next     = rnd + 6'd1;
        if (rnd == 6'd63) begin
          state_next = S_FOLD;
        end
      end
      S_FOLD: begin
        cmd.fold = 1'b1;
        if (len_done) begin
          state_next = S_DONE;
        end else if (pad_active) begin
          state_next = S_PAD;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_DONE: begin
        // hold the digest until the previous one has fully drained
        if (!out_busy) begin
          cmd.digest_load = 1'b1;
          cmd.clear_msg   = 1'b1;
          pad_active_next = 1'b0;
          mark_done_next  = 1'b0;
          len_phase_next  = 1'b0;
          len_done_next   = 1'b0;
          state_next      = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

### rtl/core/shamh_datapath.sv
// Datapath: 512-bit block/schedule shift register, round logic, chain value, length counter.
// Depends on shamh_pkg; steered by shamh_ctrl through cmd_t.
module shamh_datapath (
  input  logic             clk,
  input  logic             rst,
  input  logic [7:0]       data_byte,
  input  shamh_pkg::cmd_t  cmd,
  output shamh_pkg::stat_t stat,
  output logic [255:0]     digest
);
  import shamh_pkg::*;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [31:0] sig0(input logic [31:0] x);
    sig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [31:0] sig1(input logic [31:0] x);
    sig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

  function automatic logic [31:0] big0(input logic [31:0] x);
    big0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic logic [31:0] big1(input logic [31:0] x);
    big1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

  logic [511:0] window;
  logic [31:0]  v [8];
  logic [31:0]  chain [8];
  logic [60:0]  byte_count;
  logic [5:0]   pos;

  logic [63:0]  bit_count;
  logic [7:0]   len_b [8];
  logic [7:0]   byte_in;
  logic [31:0]  w_cur, w_new;
  logic [31:0]  t1, t2;

  assign bit_count = {byte_count, 3'b000};
  assign stat.pos  = pos;

  for (genvar i = 0; i < 8; i++) begin : g_len
    assign len_b[i] = bit_count[63-8*i -: 8];
    assign digest[255-32*i -: 32] = chain[i];
  end

  always_comb begin
    unique case (cmd.byte_sel)
      SEL_DATA: byte_in = data_byte;
      SEL_MARK: byte_in = PAD_MARK;
      SEL_ZERO: byte_in = 8'h00;
      SEL_LEN:  byte_in = len_b[pos[2:0]];
      default:  byte_in = 8'h00;
    endcase
  end

  // window word k sits at [511-32k]; word 0 is the one used this round
  assign w_cur = window[511:480];
  assign w_new = sig1(window[511-32*14 -: 32]) + window[511-32*9 -: 32]
               + sig0(window[511-32*1 -: 32]) + w_cur;

  assign t1 = v[7] + big1(v[4]) + ((v[4] & v[5]) ^ (~v[4] & v[6]))
            + ROUND_K[cmd.round] + w_cur;
  assign t2 = big0(v[0]) + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));

  always_ff @(posedge clk) begin
    if (cmd.shift_byte) begin
      window <= {window[503:0], byte_in};
    end else if (cmd.round_en) begin
      window <= {window[479:0], w_new};
    end
    if (cmd.init_vars) begin
      for (int i = 0; i < 8; i++) begin
        v[i] <= chain[i];
      end
    end else if (cmd.round_en) begin
      v[0] <= t1 + t2;
      v[1] <= v[0];
      v[2] <= v[1];
      v[3] <= v[2];
      v[4] <= v[3] + t1;
      v[5] <= v[4];
      v[6] <= v[5];
      v[7] <= v[6];
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.clear_msg) begin
      for (int i = 0; i < 8; i++) begin
        chain[i] <= INIT_HASH[i];
      end
      byte_count <= '0;
      pos        <= '0;
    end else begin
      if (cmd.fold) begin
        for (int i = 0; i < 8; i++) begin
          chain[i] <= chain[i] + v[i];
        end
      end
      if (cmd.count_en) begin
        byte_count <= byte_count + 61'd1;
      end
      if (cmd.shift_byte) begin
        pos <= pos + 6'd1;
      end
    end
  end

endmodule

### rtl/core/shamh_outbuf.sv
// Digest output buffer: holds one finished hash and hands it out a word at a time.
// Depends on shamh_pkg for the word width WordW only.
module shamh_outbuf (
  input  logic         clk,
  input  logic         rst,
  input  logic         load,
  input  logic [255:0] digest,
  output logic         busy,
  output logic         out_valid,
  input  logic         out_ready,
  output logic [31:0]  digest_word,
  output logic [2:0]   word_index,
  output logic         last_word
);
  import shamh_pkg::*;

  logic [255:0] dbuf;
  logic [2:0]   idx;
  logic         full;

  assign busy        = full;
  assign out_valid   = full;
  assign digest_word = dbuf[255:224];
  assign word_index  = idx;
  assign last_word   = (idx == 3'd7);

  always_ff @(posedge clk) begin
    if (load) begin
      dbuf <= digest;
    end else if (full && out_ready) begin
      dbuf <= {dbuf[223:0], {WordW{1'b0}}};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
      idx  <= '0;
    end else if (load) begin
      full <= 1'b1;
      idx  <= '0;
    end else if (full && out_ready) begin
      idx <= idx + 3'd1;
      if (idx == 3'd7) begin
        full <= 1'b0;
      end
    end
  end

endmodule

### rtl/core/sha256_message_hasher.sv
// SHA-256 message hasher, top level: sequencer, datapath and digest buffer.
// Depends on shamh_pkg, shamh_ctrl, shamh_datapath, shamh_outbuf.
//
//   channel  handshake            payload
//   in       in_valid/in_ready    data_byte[7:0], byte_valid, last_byte
//   out      out_valid/out_ready  digest_word[31:0], word_index[2:0], last_word
//
// Message bytes are taken one per cycle while in_ready is high; every 64th byte starts
// 64 rounds of the single round unit plus one chain update.
// The last byte adds the padding bytes and one or two more compressions.
// Digest words leave from their own buffer, so the next message loads while they drain.
// Synchronous active-high reset; no clearing pass. A stalled output keeps a finished
// digest in the datapath, and input waits until the buffer is free.
module sha256_message_hasher (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        byte_valid,
  input  logic        last_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] digest_word,
  output logic [2:0]  word_index,
  output logic        last_word
);
  import shamh_pkg::*;

  cmd_t         cmd;
  stat_t        stat;
  logic         out_busy;
  logic [255:0] digest;

  shamh_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .byte_valid (byte_valid),
    .last_byte  (last_byte),
    .stat       (stat),
    .out_busy   (out_busy),
    .cmd        (cmd)
  );

  shamh_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .data_byte (data_byte),
    .cmd       (cmd),
    .stat      (stat),
    .digest    (digest)
  );

  shamh_outbuf u_out (
    .clk         (clk),
    .rst         (rst),
    .load        (cmd.digest_load),
    .digest      (digest),
    .busy        (out_busy),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .digest_word (digest_word),
    .word_index  (word_index),
    .last_word   (last_word)
  );

`ifndef SYNTHESIS
  // a new digest must never overwrite one still being read out
  a_load_when_free: assert property (@(posedge clk) disable iff (rst)
    cmd.digest_load |-> !out_valid)
    else $error("digest loaded while buffer busy");

  // the eighth word empties the buffer
  a_drain_after_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && last_word) |=> !out_valid)
    else $error("buffer still valid after last word");

  // end of message starts padding, so no further byte is taken at once
  a_pad_blocks_input: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && last_byte) |=> !in_ready)
    else $error("input taken during padding");
`endif

endmodule
